>>> rtl/core/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package bba_pkg;

  // Field widths fixed by the request / result formats
  localparam int unsigned OP_W  = 2;
  localparam int unsigned BLK_W = 14;
  localparam int unsigned CNT_W = 15;
  localparam int unsigned ST_W  = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd1;
  localparam logic [CNT_W-1:0]     TOTAL_RST    = 15'd16384;
  localparam logic [CNT_W-1:0]     RESERVED_RST = 15'd0;

  // Default geometry of the usage map
  localparam int unsigned DEF_MAX_BLOCKS = 16384;
  localparam int unsigned DEF_WORD_BITS  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_FORMAT = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  // Classified request, front to back
  typedef struct packed {
    op_e              op;
    logic [BLK_W-1:0] blk;
    logic             oor;   // block at or past the effective total
  } job_t;

  typedef struct packed {
    status_e          status;
    logic [BLK_W-1:0] blk;
    logic             bit_value;
    logic [CNT_W-1:0] free_left;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/bba_front.sv
// Request front end: input handshake and range classification.
// Depends on bba_pkg.
`default_nettype none

module bba_front (
  input  wire logic                      s_valid_i,
  output logic                           s_ready_o,
  input  wire logic [bba_pkg::OP_W-1:0]  op_i,
  input  wire logic [bba_pkg::BLK_W-1:0] blk_i,
  input  wire logic [bba_pkg::CNT_W-1:0] total_eff_i,
  input  wire logic                      init_done_i,
  input  wire logic                      q_full_i,
  output logic                           q_push_o,
  output bba_pkg::job_t                  q_job_o
);
  import bba_pkg::*;

  // no beat taken while the map is being cleared after reset
  assign s_ready_o = init_done_i && !q_full_i;
  assign q_push_o  = s_valid_i && s_ready_o;

  always_comb begin
    q_job_o.op  = op_e'(op_i);
    q_job_o.blk = blk_i;
    q_job_o.oor = (CNT_W'(blk_i) >= total_eff_i);
  end

endmodule

`default_nettype wire

>>> rtl/core/bba_queue.sv
// Two-entry job queue between front end and engine.
// Depends on bba_pkg.
`default_nettype none

module bba_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  bba_pkg::job_t      job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output bba_pkg::job_t      job_o
);
  import bba_pkg::*;

  localparam int unsigned DEPTH = 2;

  job_t        mem_q [DEPTH];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'(DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

`default_nettype wire

>>> rtl/core/bba_back.sv
// Allocation engine: usage map memory, free counter, scan/format sequencer,
// result register. Depends on bba_pkg. WORD_BITS must be a power of two.
`default_nettype none

module bba_back #(
  parameter int unsigned MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [bba_pkg::CNT_W-1:0] total_eff_i,
  input  wire logic [bba_pkg::CNT_W-1:0] reserved_i,
  output logic                           init_done_o,
  input  wire logic                      job_valid_i,
  input  bba_pkg::job_t                  job_i,
  output logic                           job_pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output bba_pkg::result_t               out_o
);
  import bba_pkg::*;

  localparam int unsigned WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BW     = $clog2(WORD_BITS);
  localparam int unsigned IDX_W  = AW + BW;
  localparam int unsigned CMP_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int unsigned WIDE_W = IDX_W + BLK_W;
  localparam logic [AW-1:0]    LAST_WORD = AW'(WORDS - 1);
  localparam logic [CNT_W-1:0] WB_CNT    = CNT_W'(WORD_BITS);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_CHECK  = 6'b001000,
    S_FORMAT = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          sweep_q, sweep_d;
  logic [CNT_W-1:0]       left_q, left_d;
  logic [CNT_W-1:0]       free_q, free_d;
  logic                   out_valid_q, out_valid_d;
  logic [AW-1:0]          issue_q, issue_d, pend_q, pend_d;
  status_e                rs_status_q, rs_status_d;
  logic [BLK_W-1:0]       rs_blk_q, rs_blk_d;
  logic                   rs_bit_q, rs_bit_d;
  result_t                out_q, out_d;

  // usage map
  logic [WORD_BITS-1:0]   map_mem [WORDS];
  logic [WORD_BITS-1:0]   rd_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic [WORD_BITS-1:0]   mem_wd;

  logic [WIDE_W-1:0]      blk_wide;
  logic [AW-1:0]          blk_word;
  logic [BW-1:0]          blk_bit;
  logic                   blk_used;
  logic                   word_full;
  logic [BW-1:0]          fz_bit;
  logic [IDX_W-1:0]       cand;
  logic                   cand_ok;
  logic                   left_ge;
  logic [WORD_BITS-1:0]   sweep_word;
  logic [CNT_W-1:0]       res_eff;
  logic                   out_load;

  assign blk_wide = WIDE_W'(job_i.blk);
  assign blk_word = blk_wide[IDX_W-1:BW];
  assign blk_bit  = blk_wide[BW-1:0];
  assign blk_used = rd_q[blk_bit];

  // lowest clear bit of the word under test
  assign word_full = &rd_q;
  always_comb begin
    fz_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_q[i]) fz_bit = BW'(i);
    end
  end
  assign cand    = {pend_q, fz_bit};
  assign cand_ok = (CMP_W'(cand) < CMP_W'(total_eff_i));

  // format fill pattern: whole words of reserved blocks, then a partial mask
  assign left_ge    = (left_q >= WB_CNT);
  assign sweep_word = left_ge ? '1 : ~({WORD_BITS{1'b1}} << left_q[BW-1:0]);
  assign res_eff    = (reserved_i < total_eff_i) ? reserved_i : total_eff_i;

  assign init_done_o = (state_q != S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    left_d      = left_q;
    free_d      = free_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    rs_status_d = rs_status_q;
    rs_blk_d    = rs_blk_q;
    rs_bit_d    = rs_bit_q;
    out_d       = out_q;
    out_load    = 1'b0;
    job_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = sweep_q;
    mem_wd      = sweep_word;
    mem_ra      = blk_word;

    unique case (state_q)
      S_CLEAR, S_FORMAT: begin
        mem_we  = 1'b1;
        sweep_d = sweep_q + AW'(1);
        left_d  = left_ge ? (left_q - WB_CNT) : '0;
        if (sweep_q == LAST_WORD) begin
          sweep_d = '0;
          if (state_q == S_CLEAR) begin
            state_d = S_IDLE;
          end else begin
            rs_status_d = ST_OK;
            rs_blk_d    = '0;
            rs_bit_d    = 1'b0;
            state_d     = S_DONE;
          end
        end
      end
      S_IDLE: begin
        mem_ra   = (job_i.op == OP_ALLOC) ? '0 : blk_word;
        rs_bit_d = 1'b0;
        if (job_valid_i) begin
          unique case (job_i.op)
            OP_ALLOC: begin
              if (free_q == '0) begin
                rs_status_d = ST_NO_FREE;
                rs_blk_d    = '0;
                state_d     = S_DONE;
              end else begin
                pend_d  = '0;
                issue_d = AW'(1);
                state_d = S_SCAN;
              end
            end
            OP_FREE, OP_QUERY: begin
              rs_blk_d = job_i.blk;
              if (job_i.oor) begin
                rs_status_d = ST_OUT_OF_RANGE;
                state_d     = S_DONE;
              end else begin
                state_d = S_CHECK;
              end
            end
            OP_FORMAT: begin
              left_d  = res_eff;
              sweep_d = '0;
              free_d  = total_eff_i - res_eff;
              state_d = S_FORMAT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        // one word read per cycle; rd_q holds word pend_q
        mem_ra  = issue_q;
        issue_d = issue_q + AW'(1);
        pend_d  = issue_q;
        if (!word_full) begin
          if (cand_ok) begin
            mem_we      = 1'b1;
            mem_wa      = pend_q;
            mem_wd      = rd_q | (WORD_BITS'(1) << fz_bit);
            free_d      = free_q - CNT_W'(1);
            rs_status_d = ST_OK;
            rs_blk_d    = CMP_W'(cand) >> 0 == '0 ? '0 : BLK_W'(CMP_W'(cand));
          end else begin
            rs_status_d = ST_NO_FREE;
            rs_blk_d    = '0;
          end
          state_d = S_DONE;
        end else if (pend_q == LAST_WORD) begin
          rs_status_d = ST_NO_FREE;
          rs_blk_d    = '0;
          state_d     = S_DONE;
        end
      end
      S_CHECK: begin
        rs_status_d = ST_OK;
        if (job_i.op == OP_QUERY) begin
          rs_bit_d = blk_used;
        end else if (!blk_used) begin
          rs_status_d = ST_ALREADY_FREE;
        end else begin
          mem_we = 1'b1;
          mem_wa = blk_word;
          mem_wd = rd_q & ~(WORD_BITS'(1) << blk_bit);
          free_d = free_q + CNT_W'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load        = 1'b1;
          job_pop_o       = 1'b1;
          out_d.status    = rs_status_q;
          out_d.blk       = rs_blk_q;
          out_d.bit_value = rs_bit_q;
          out_d.free_left = free_q;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      sweep_q     <= '0;
      left_q      <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      left_q      <= left_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q     <= issue_d;
    pend_q      <= pend_d;
    rs_status_q <= rs_status_d;
    rs_blk_q    <= rs_blk_d;
    rs_bit_q    <= rs_bit_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_wa] <= mem_wd;
    rd_q <= map_mem[mem_ra];
  end

endmodule

`default_nettype wire

>>> rtl/core/bitmap_block_allocator.sv
// Top level of the bitmap first-fit block allocator: config registers,
// front end, job queue and allocation engine. Depends on bba_pkg,
// bba_front, bba_queue, bba_back.
//
//   channel  dir  handshake                    payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  operation, block_number
//   m_axis   out  m_axis_tvalid/m_axis_tready  status, result_block,
//                                              bit_value, free_left
//   cfg      in   cfg_we_i (no wait)           cfg_index_i, cfg_data_i
//
// Allocate reads the usage map through its single read port, scanned one
// word per cycle from word 0. Free and query read the word that holds the
// block; format rewrites every word of the map.
// Reset: the map is cleared by a sweep over all WORDS words (512 at defaults);
// s_axis_tready stays low until it is done. Config writes are always taken.
// Stalls: a two-beat queue decouples input from the engine; a finished
// result waits in the output register while the next request is taken.
`default_nettype none

module bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // operation[1:0], block_number[15:2]
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [31:0]                        m_axis_tdata,  // status[1:0], result_block[15:2],
                                                            // bit_value[16], free_left[31:17]
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bba_pkg::CNT_W-1:0]     cfg_data_i
);
  import bba_pkg::*;

  // effective total is capped at the map size
  localparam logic [CNT_W-1:0] MAX_CAP =
      (MAX_BLOCKS > (2**CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(MAX_BLOCKS);

  logic [CNT_W-1:0] total_q, reserved_q;
  logic [CNT_W-1:0] total_eff;

  logic    init_done;
  logic    q_full, q_push, q_valid, q_pop;
  job_t    push_job, head_job;
  result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= TOTAL_RST;
      reserved_q <= RESERVED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TOTAL:    total_q    <= cfg_data_i;
        CFG_RESERVED: reserved_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign total_eff = (total_q > MAX_CAP) ? MAX_CAP : total_q;

  bba_front u_front (
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .op_i        (s_axis_tdata[1:0]),
    .blk_i       (s_axis_tdata[15:2]),
    .total_eff_i (total_eff),
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  bba_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  bba_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .total_eff_i (total_eff),
    .reserved_i  (reserved_q),
    .init_done_o (init_done),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .job_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  assign m_axis_tdata = {result.free_left, result.bit_value, result.blk, result.status};

endmodule

`default_nettype wire

>>> verif/bba_alloc_checker.sv
// Result checker for the bitmap block allocator: tracks the usage map, free
// count and registers from the request and config beats, then checks each
// result beat. Depends on bba_pkg.
module bba_alloc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic [15:0]                   req_data_i,   // operation[1:0], block_number[15:2]
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [31:0]                   res_data_i,   // status[1:0], result_block[15:2],
                                                      // bit_value[16], free_left[31:17]
  input  logic                          cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bba_pkg::CNT_W-1:0]     cfg_data_i,
  output int                            mismatches_o,
  output int                            awaited_o,
  output int                            checked_o
);
  import bba_pkg::*;

  localparam int MAP_WORDS = DEF_MAX_BLOCKS / DEF_WORD_BITS;

  logic [DEF_WORD_BITS-1:0] usage_words [MAP_WORDS];
  logic [CNT_W-1:0]         free_blocks;
  logic [CNT_W-1:0]         total_reg;
  logic [CNT_W-1:0]         reserved_reg;
  result_t                  awaited_q [$];
  result_t                  seen;
  result_t                  want;

  task automatic report_mismatch(string what, int got, int wanted);
    $display("alloc check: %s at %0t: got %0d, want %0d", what, $time, got, wanted);
    mismatches_o = mismatches_o + 1;
  endtask

  // total clipped to the size of the map
  function automatic logic [CNT_W-1:0] usable_blocks();
    return (total_reg > DEF_MAX_BLOCKS) ? CNT_W'(DEF_MAX_BLOCKS) : total_reg;
  endfunction

  // Applies one request to the tracked map and returns the result it gives.
  function automatic result_t apply_request(op_e op, logic [BLK_W-1:0] blk);
    result_t          r;
    logic [CNT_W-1:0] limit;
    int               w;
    int               b;
    int               cand;
    int               keep;
    logic             hit;
    limit       = usable_blocks();
    r.status    = ST_OK;
    r.blk       = '0;
    r.bit_value = 1'b0;
    case (op)
      OP_ALLOC: begin
        hit = 1'b0;
        if (free_blocks != 0) begin
          // first-fit: lowest clear bit of the first non-full word only
          w = 0;
          while (w < MAP_WORDS && &usage_words[w]) w++;
          if (w < MAP_WORDS) begin
            b = 0;
            while (usage_words[w][b]) b++;
            cand = w * DEF_WORD_BITS + b;
            if (cand < limit) begin
              usage_words[w][b] = 1'b1;
              free_blocks       = free_blocks - 1'b1;
              r.blk             = cand[BLK_W-1:0];
              hit               = 1'b1;
            end
          end
        end
        if (!hit) r.status = ST_NO_FREE;
      end
      OP_FREE: begin
        r.blk = blk;
        if (blk >= limit) begin
          r.status = ST_OUT_OF_RANGE;
        end else if (!usage_words[blk / DEF_WORD_BITS][blk % DEF_WORD_BITS]) begin
          r.status = ST_ALREADY_FREE;
        end else begin
          usage_words[blk / DEF_WORD_BITS][blk % DEF_WORD_BITS] = 1'b0;
          free_blocks = free_blocks + 1'b1;
        end
      end
      OP_QUERY: begin
        r.blk = blk;
        if (blk >= limit) r.status = ST_OUT_OF_RANGE;
        else r.bit_value = usage_words[blk / DEF_WORD_BITS][blk % DEF_WORD_BITS];
      end
      default: begin
        keep = (reserved_reg > limit) ? limit : reserved_reg;
        for (w = 0; w < MAP_WORDS; w++) usage_words[w] = '0;
        for (b = 0; b < keep; b++) usage_words[b / DEF_WORD_BITS][b % DEF_WORD_BITS] = 1'b1;
        free_blocks = limit - CNT_W'(keep);
      end
    endcase
    r.free_left = free_blocks;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAP_WORDS; i++) usage_words[i] = '0;
      free_blocks  = '0;
      total_reg    = TOTAL_RST;
      reserved_reg = RESERVED_RST;
      awaited_q.delete();
      awaited_o    = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        seen.status    = status_e'(res_data_i[1:0]);
        seen.blk       = res_data_i[15:2];
        seen.bit_value = res_data_i[16];
        seen.free_left = res_data_i[31:17];
        if (awaited_q.size() == 0) begin
          report_mismatch("result beat with no request outstanding, status", seen.status, 0);
        end else begin
          want = awaited_q.pop_front();
          if (seen.status != want.status)
            report_mismatch("status", seen.status, want.status);
          if (seen.blk != want.blk)
            report_mismatch("result_block", seen.blk, want.blk);
          if (seen.bit_value != want.bit_value)
            report_mismatch("bit_value", seen.bit_value, want.bit_value);
          if (seen.free_left != want.free_left)
            report_mismatch("free_left", seen.free_left, want.free_left);
          checked_o = checked_o + 1;
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TOTAL:    total_reg    = cfg_data_i;
          CFG_RESERVED: reserved_reg = cfg_data_i;
          default:      ;
        endcase
      end
      if (req_valid_i && req_ready_i)
        awaited_q.push_back(apply_request(op_e'(req_data_i[1:0]), req_data_i[15:2]));
      awaited_o = awaited_q.size();
    end
  end

  initial begin
    mismatches_o = 0;
    checked_o    = 0;
  end

endmodule

>>> verif/bitmap_block_allocator_tb.sv
// Testbench top for bitmap_block_allocator: clock, reset, request and config
// stimulus, result-side backpressure and the verdict. Depends on bba_pkg,
// the allocator RTL and bba_alloc_checker.
module bitmap_block_allocator_tb;
  import bba_pkg::*;

  // Slowest beat is a full map scan; ~1200 beats plus stalls stay well under
  // the limit, so this only trips on a hang.
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int DRAIN_CYCLES  = 600;     // > longest scan / format sweep
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BEATS   = 95;
  localparam int MAX_BLK       = 16383;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;   // operation[1:0], block_number[15:2]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;         // status[1:0], result_block[15:2],
                                              // bit_value[16], free_left[31:17]
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CNT_W-1:0]     cfg_data_i    = '0;

  int mismatches;
  int awaited;
  int checked;

  // Stimulus bookkeeping; block picks aim at the region the map really uses.
  int  cycle_count  = 0;
  int  sent_beats   = 0;
  int  settings_cnt = 0;
  int  usable       = DEF_MAX_BLOCKS;     // effective total as last programmed
  int  res_eff      = 0;                  // effective reserved count
  int  alloc_sent   = 0;                  // allocs since the last format
  bit  calm         = 1'b0;               // phase without any idling
  int  result_gap   = 0;
  bit  result_taken = 1'b0;

  always #10 clk_i = ~clk_i;

  bitmap_block_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  bba_alloc_checker u_alloc_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .awaited_o    (awaited),
    .checked_o    (checked)
  );

  // Idle cycles before a beat; zero all through a calm phase.
  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Result side: after each accepted beat, hold tready low for a fresh gap.
  always @(posedge clk_i) result_taken <= m_axis_tvalid && m_axis_tready;

  always @(negedge clk_i) begin
    if (result_taken) result_gap = draw_gap();
    if (result_gap > 0) begin
      m_axis_tready <= 1'b0;
      result_gap    = result_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, awaited);
      $display("bitmap_block_allocator: mismatch");
      $finish;
    end
  end

  // Entered and left just after a falling edge. tvalid stays high across
  // back-to-back beats, so it never gets two assignments in one step.
  task automatic send_request(op_e op, logic [BLK_W-1:0] blk);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blk, op};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent_beats = sent_beats + 1;
    if (op == OP_FORMAT) alloc_sent = 0;
    if (op == OP_ALLOC) alloc_sent = alloc_sent + 1;
  endtask

  // Stop sending and let every outstanding result drain.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Registers only change with the block idle.
  task automatic set_geometry(int total, int reserved);
    wait_idle();
    write_reg(CFG_TOTAL, CNT_W'(total));
    write_reg(CFG_RESERVED, CNT_W'(reserved));
    usable       = (total > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : total;
    res_eff      = (reserved > usable) ? usable : reserved;
    settings_cnt = settings_cnt + 1;
  endtask

  // Mostly blocks around the reserved area and recent allocs, so frees and
  // queries hit used bits; some at the total boundary, some anywhere, some at 0 or the top.
  function automatic logic [BLK_W-1:0] pick_block();
    int sel;
    int lo;
    int hi;
    int b;
    sel = $urandom_range(0, 9);
    lo  = (res_eff > 4) ? res_eff - 4 : 0;
    hi  = res_eff + alloc_sent + 2;
    if (hi > MAX_BLK) hi = MAX_BLK;
    if (sel <= 5) begin
      b = $urandom_range(hi, lo);
    end else if (sel <= 7) begin
      b = usable + $urandom_range(0, 3) - 2;
    end else if (sel == 8) begin
      b = $urandom_range(0, MAX_BLK);
    end else begin
      b = $urandom_range(0, 1) ? MAX_BLK : 0;
    end
    if (b < 0) b = 0;
    if (b > MAX_BLK) b = MAX_BLK;
    return b[BLK_W-1:0];
  endfunction

  task automatic random_phase(int phase);
    int total;
    int reserved;
    int roll;
    op_e op;
    case (phase)
      0:       begin total = 16384; reserved = 0;     end
      1:       begin total = 32;    reserved = 0;     end
      2:       begin total = 1;     reserved = 0;     end
      3:       begin total = 33;    reserved = 32;    end
      4:       begin total = 100;   reserved = 16384; end   // reserved past total
      5:       begin total = 64;    reserved = $urandom_range(0, 64); end
      6:       begin total = $urandom_range(1, 16384); reserved = $urandom_range(0, total); end
      7:       begin total = 16384; reserved = 16000; end   // long scans
      8:       begin total = 16383; reserved = 16383; end   // no block left: every usable block reserved
      9:       begin total = 500;   reserved = 17;    end
      10:      begin total = 31;    reserved = 31;    end
      default: begin total = $urandom_range(1, 300); reserved = $urandom_range(0, total); end
    endcase
    set_geometry(total, reserved);
    calm = ($urandom_range(0, 3) == 0);
    // Usually start from a fresh map; otherwise keep the stale one.
    if (phase == 0 || $urandom_range(0, 5) != 0) send_request(OP_FORMAT, pick_block());
    repeat (PHASE_BEATS) begin
      roll = $urandom_range(0, 99);
      if (roll < 42)      op = OP_ALLOC;
      else if (roll < 72) op = OP_FREE;
      else if (roll < 97) op = OP_QUERY;
      else                op = OP_FORMAT;
      send_request(op, pick_block());
      if ($urandom_range(0, 49) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed ----
    // Before any format the free count is zero and the map is clear.
    send_request(OP_ALLOC, '0);            // no free block
    send_request(OP_FREE, 14'd5);          // already free
    send_request(OP_QUERY, 14'd16383);     // top block, clear

    set_geometry(40, 3);
    send_request(OP_FORMAT, 14'h3FFF);
    send_request(OP_ALLOC, 14'h2AAA);      // takes 3
    send_request(OP_ALLOC, 14'h1555);      // takes 4
    send_request(OP_QUERY, 14'd3);
    send_request(OP_FREE, 14'd3);
    send_request(OP_FREE, 14'd3);          // second free of the same block
    send_request(OP_ALLOC, '0);            // reuses 3
    send_request(OP_FREE, 14'd40);         // at the total: out of range
    send_request(OP_FREE, 14'd0);          // a reserved block can be freed
    send_request(OP_ALLOC, '0);            // and taken again

    set_geometry(1, 0);
    send_request(OP_FORMAT, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);            // map exhausted

    // Shrink the total without a format: first clear bit lies past the total
    // while the free count is still nonzero.
    set_geometry(64, 8);
    send_request(OP_FORMAT, '0);
    set_geometry(8, 8);
    send_request(OP_ALLOC, '0);
    send_request(OP_QUERY, 14'd8);

    set_geometry(16384, 16384);            // everything reserved
    send_request(OP_FORMAT, '0);
    send_request(OP_QUERY, 14'd16383);
    send_request(OP_ALLOC, '0);

    set_geometry(0, 0);                    // zero total: nothing in range
    send_request(OP_FORMAT, '0);
    send_request(OP_QUERY, 14'd0);
    send_request(OP_ALLOC, '0);

    // ---- random ----
    for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run covered %0d request beats over %0d register settings", sent_beats,
             settings_cnt);
    $display("%0d result beats compared, %0d field mismatches", checked, mismatches);
    if (mismatches == 0)
      $display("bitmap_block_allocator: match");
    else
      $display("bitmap_block_allocator: mismatch");
    $finish;
  end

endmodule
